// ===== rtl/core/rsfg_pkg.sv =====
// Shared types and constants for the restriction site fragment grouper.
// Used by the top level and rsfg_emit in rtl/core; depends on nothing.
package rsfg_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_MOTIF_LEN  = 2'd0;
    localparam logic [1:0] CFG_MOTIF_LOW  = 2'd1;
    localparam logic [1:0] CFG_MOTIF_HIGH = 2'd2;
    localparam logic [1:0] CFG_GROUP_SPAN = 2'd3;

    // reset values of the configuration registers ("ACTAGT", span 600000)
    localparam logic [4:0]  RST_MOTIF_LEN  = 5'd6;
    localparam logic [63:0] RST_MOTIF_LOW  = 64'h0000_5447_4154_4341;
    localparam logic [63:0] RST_MOTIF_HIGH = 64'h0;
    localparam logic [31:0] RST_GROUP_SPAN = 32'd600000;

    // a sequence-end flush needs more than this many lengths
    localparam int FLUSH_MIN = 3;

    // record kinds on m_tuser
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_LENGTH = 1'b1;

    localparam int M_TDATA_W = 88;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_HEAD,
        EMIT_READ
    } emit_state_t;

    // snapshot of a group handed to the emitter
    typedef struct packed {
        logic [15:0] seq;
        logic [31:0] start;
        logic [31:0] count;
        logic        ovf;
    } emit_req_t;

endpackage

// ===== rtl/core/restriction_site_fragment_grouper_top.sv =====
// Top level of the restriction site fragment grouper: configuration, site and
// group bookkeeping, length store. Depends on rsfg_pkg, rsfg_ram, rsfg_match, rsfg_emit.

// One DNA character is taken per cycle while no group is being emitted. A
// transaction that closes a group, or ends a sequence with more than three
// stored lengths, hands the group to the emitter; the input then stalls until
// the header and every length of the group are out, since the lengths leave
// the length store one per cycle, while the output is free, through its single
// read port. No clearing pass is needed after reset. Configuration is written
// through cfg_wr_en/cfg_index/cfg_wr_data and must only change while idle.
module restriction_site_fragment_grouper_top #(
    parameter int MAX_MOTIF      = 16,
    parameter int LENGTH_DEPTH   = 63,
    parameter int POSITION_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // base_char[7:0]
    input  logic        s_tlast,   // end_of_sequence
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [rsfg_pkg::M_TDATA_W-1:0] m_tdata, // sequence_number[15:0] group_start[47:16]
                                                    // record_value[79:48] overflowed[80]
    output logic        m_tuser,   // record_kind
    output logic        m_tlast    // last_record
);

    localparam int POS_W  = POSITION_WIDTH;
    localparam int CNT_W  = $clog2(LENGTH_DEPTH + 1);
    localparam int ADDR_W = $clog2(LENGTH_DEPTH);

    logic [4:0]  motif_len_reg;
    logic [63:0] motif_low_reg;
    logic [63:0] motif_high_reg;
    logic [31:0] span_reg;

    logic [POS_W-1:0] prev_site_reg, prev_site_next;
    logic             site_seen_reg, site_seen_next;
    logic [POS_W-1:0] grp_start_reg, grp_start_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [15:0]      seq_reg, seq_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [31:0]      pend_len_reg, pend_len_next;

    logic [4:0]       len_eff;
    logic             accept;
    logic             hit;
    logic [POS_W-1:0] site;
    logic [POS_W+31:0] frag_wide;
    logic [POS_W+31:0] dist_wide;
    logic [31:0]      frag;
    logic             closes;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [31:0]       ram_rdata;

    logic                emit_req_valid;
    rsfg_pkg::emit_req_t emit_req;
    logic                emit_idle;
    logic                emit_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motif_len_reg  <= rsfg_pkg::RST_MOTIF_LEN;
            motif_low_reg  <= rsfg_pkg::RST_MOTIF_LOW;
            motif_high_reg <= rsfg_pkg::RST_MOTIF_HIGH;
            span_reg       <= rsfg_pkg::RST_GROUP_SPAN;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rsfg_pkg::CFG_MOTIF_LEN:  motif_len_reg  <= cfg_wr_data[4:0];
                rsfg_pkg::CFG_MOTIF_LOW:  motif_low_reg  <= cfg_wr_data;
                rsfg_pkg::CFG_MOTIF_HIGH: motif_high_reg <= cfg_wr_data;
                rsfg_pkg::CFG_GROUP_SPAN: span_reg       <= cfg_wr_data[31:0];
                default: ;
            endcase
        end
    end

    assign len_eff  = (motif_len_reg > 5'(MAX_MOTIF)) ? 5'(MAX_MOTIF) : motif_len_reg;
    assign s_tready = emit_idle;
    assign accept   = s_tvalid && s_tready;

    rsfg_match #(
        .MAX_MOTIF (MAX_MOTIF),
        .POS_W     (POS_W)
    ) u_match (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (accept),
        .clear       (s_tlast),
        .base_char   (s_tdata),
        .motif_len   (len_eff),
        .motif_chars ({motif_high_reg, motif_low_reg}),
        .hit         (hit),
        .site        (site)
    );

    // widened differences: wrap behaves as in 64-bit arithmetic, masked to 32 bits
    assign frag_wide = {32'b0, site} - {32'b0, prev_site_reg};
    assign dist_wide = {32'b0, site} - {32'b0, grp_start_reg};
    assign frag      = frag_wide[31:0];
    assign closes    = dist_wide > {{POS_W{1'b0}}, span_reg};

    always_comb begin
        logic [POS_W+31:0] start_wide;
        prev_site_next  = prev_site_reg;
        site_seen_next  = site_seen_reg;
        grp_start_next  = grp_start_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        seq_next        = seq_reg;
        pend_valid_next = pend_valid_reg;
        pend_len_next   = pend_len_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[ADDR_W-1:0];
        ram_wdata       = frag;
        emit_req_valid  = 1'b0;
        start_wide      = {32'b0, grp_start_reg};
        emit_req.seq    = seq_reg;
        emit_req.start  = start_wide[31:0];
        emit_req.count  = 32'(count_reg);
        emit_req.ovf    = ovf_reg;

        // first length of a new group waits until the old group has been read out
        if (emit_done && pend_valid_reg) begin
            ram_we          = 1'b1;
            ram_waddr       = '0;
            ram_wdata       = pend_len_reg;
            pend_valid_next = 1'b0;
        end

        if (accept) begin
            if (hit) begin
                if (!site_seen_reg) begin
                    site_seen_next = 1'b1;
                    prev_site_next = site;
                    grp_start_next = site;
                end else begin
                    prev_site_next = site;
                    if (closes) begin
                        emit_req_valid  = 1'b1;
                        grp_start_next  = site;
                        count_next      = CNT_W'(1);
                        ovf_next        = 1'b0;
                        pend_valid_next = 1'b1;
                        pend_len_next   = frag;
                    end else if (count_reg < CNT_W'(LENGTH_DEPTH)) begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            if (s_tlast) begin
                // a closing site leaves one length, so no second group here
                if (count_next > CNT_W'(rsfg_pkg::FLUSH_MIN)) begin
                    start_wide     = {32'b0, grp_start_next};
                    emit_req_valid = 1'b1;
                    emit_req.start = start_wide[31:0];
                    emit_req.count = 32'(count_next);
                    emit_req.ovf   = ovf_next;
                end
                site_seen_next = 1'b0;
                prev_site_next = '0;
                grp_start_next = '0;
                count_next     = '0;
                ovf_next       = 1'b0;
                seq_next       = seq_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_site_reg  <= '0;
            site_seen_reg  <= 1'b0;
            grp_start_reg  <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            seq_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            prev_site_reg  <= prev_site_next;
            site_seen_reg  <= site_seen_next;
            grp_start_reg  <= grp_start_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            seq_reg        <= seq_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_len_reg <= pend_len_next;
    end

    rsfg_ram #(
        .WIDTH (32),
        .DEPTH (LENGTH_DEPTH)
    ) u_len_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rsfg_emit #(
        .ADDR_W (ADDR_W)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (emit_req_valid),
        .req       (emit_req),
        .idle      (emit_idle),
        .done      (emit_done),
        .rd_en     (ram_re),
        .rd_addr   (ram_raddr),
        .rd_data   (ram_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    a_stall_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_req_valid |=> !s_tready)
        else $error("input not stalled while a group is emitted");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LENGTH_DEPTH))
        else $error("stored length count beyond store depth");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("length store written during group read-out");

    a_pending_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> !s_tready)
        else $error("pending length outstanding while input accepted");

endmodule

// ===== rtl/core/rsfg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module rsfg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/rsfg_match.sv =====
// Motif matcher: character history, position counter and motif compare.
// Depends on nothing but its ports.
module rsfg_match #(
    parameter int MAX_MOTIF = 16,
    parameter int POS_W     = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             clear,
    input  logic [7:0]       base_char,
    input  logic [4:0]       motif_len,
    input  logic [127:0]     motif_chars,
    output logic             hit,
    output logic [POS_W-1:0] site
);

    logic [7:0]       recent_reg [MAX_MOTIF];
    logic [7:0]       shifted    [MAX_MOTIF];
    logic [7:0]       motif_bytes [16];
    logic [POS_W-1:0] seen_reg;
    logic [POS_W-1:0] seen_next;
    logic             all_eq;

    always_comb begin
        shifted[0] = base_char;
        for (int i = 1; i < MAX_MOTIF; i++) begin
            shifted[i] = recent_reg[i-1];
        end
        for (int i = 0; i < 16; i++) begin
            motif_bytes[i] = motif_chars[8*i +: 8];
        end
    end

    // position counter saturates at all ones
    assign seen_next = (seen_reg == '1) ? seen_reg : seen_reg + POS_W'(1);

    // newest character sits at index 0 and pairs with the last motif character
    always_comb begin
        logic [4:0] k;
        all_eq = 1'b1;
        for (int j = 0; j < MAX_MOTIF; j++) begin
            k = 5'(motif_len - 5'(j) - 5'd1);
            if (5'(j) < motif_len && shifted[j] != motif_bytes[k[3:0]]) begin
                all_eq = 1'b0;
            end
        end
    end

    assign hit  = (motif_len != 5'd0) && (seen_next >= POS_W'(motif_len)) && all_eq;
    assign site = seen_next - POS_W'(motif_len);

    // history needs no reset: only characters of the current sequence are compared
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < MAX_MOTIF; i++) begin
                recent_reg[i] <= shifted[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else if (advance) begin
            seen_reg <= clear ? '0 : seen_next;
        end
    end

endmodule

// ===== rtl/core/rsfg_emit.sv =====
// Group emitter: header record, then the stored lengths read out of the RAM,
// into the output register. Depends on rsfg_pkg.
module rsfg_emit #(
    parameter int ADDR_W = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       req_valid,
    input  rsfg_pkg::emit_req_t        req,
    output logic                       idle,
    output logic                       done,
    output logic                       rd_en,
    output logic [ADDR_W-1:0]          rd_addr,
    input  logic [31:0]                rd_data,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [rsfg_pkg::M_TDATA_W-1:0] m_tdata, // seq[15:0] start[47:16] value[79:48] ovf[80]
    output logic                       m_tuser,     // record_kind
    output logic                       m_tlast
);

    rsfg_pkg::emit_state_t state_reg, state_next;
    rsfg_pkg::emit_req_t   hdr_reg, hdr_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;

    logic        m_valid_reg, m_valid_next;
    logic        kind_reg, kind_next;
    logic [15:0] seq_reg, seq_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] value_reg, value_next;
    logic        ovf_reg, ovf_next;
    logic        last_reg, last_next;

    logic out_free;
    logic is_last;

    assign out_free = !m_valid_reg || m_tready;
    assign is_last  = (32'(idx_reg) + 32'd1) == hdr_reg.count;

    always_comb begin
        state_next   = state_reg;
        hdr_next     = hdr_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_tready;
        kind_next    = kind_reg;
        seq_next     = seq_reg;
        start_next   = start_reg;
        value_next   = value_reg;
        ovf_next     = ovf_reg;
        last_next    = last_reg;
        done         = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        unique case (state_reg)
            rsfg_pkg::EMIT_IDLE: begin
                if (req_valid) begin
                    hdr_next   = req;
                    state_next = rsfg_pkg::EMIT_HEAD;
                end
            end
            rsfg_pkg::EMIT_HEAD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = rsfg_pkg::KIND_HEADER;
                    seq_next     = hdr_reg.seq;
                    start_next   = hdr_reg.start;
                    value_next   = hdr_reg.count;
                    ovf_next     = hdr_reg.ovf;
                    last_next    = (hdr_reg.count == 32'd0);
                    if (hdr_reg.count == 32'd0) begin
                        done       = 1'b1;
                        state_next = rsfg_pkg::EMIT_IDLE;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = rsfg_pkg::EMIT_READ;
                    end
                end
            end
            rsfg_pkg::EMIT_READ: begin
                // read data holds while the output is stalled: rd_en only on advance
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = rsfg_pkg::KIND_LENGTH;
                    value_next   = rd_data;
                    ovf_next     = 1'b0;
                    last_next    = is_last;
                    if (is_last) begin
                        done       = 1'b1;
                        state_next = rsfg_pkg::EMIT_IDLE;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + ADDR_W'(1);
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            default: begin
                state_next = rsfg_pkg::EMIT_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rsfg_pkg::EMIT_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_reg   <= hdr_next;
        idx_reg   <= idx_next;
        kind_reg  <= kind_next;
        seq_reg   <= seq_next;
        start_reg <= start_next;
        value_reg <= value_next;
        ovf_reg   <= ovf_next;
        last_reg  <= last_next;
    end

    assign idle     = (state_reg == rsfg_pkg::EMIT_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, ovf_reg, value_reg, start_reg, seq_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rsfg_pkg::EMIT_READ |-> 32'(idx_reg) < hdr_reg.count)
        else $error("length read beyond group count");

endmodule

// ===== test/restriction_site_fragment_grouper_top_tb.sv =====
// Self-checking testbench for restriction_site_fragment_grouper_top: a queue-fed
// stream driver, a scoreboard monitor and a built-in predictor of site grouping.
// Depends on rsfg_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module restriction_site_fragment_grouper_top_tb;

    localparam int MOTIF_MAX    = 16;
    localparam int LENGTH_SLOTS = 63;
    localparam int DRAIN_CYCLES = 100;
    localparam int RX_HOLD_CYCLES = 400;
    localparam logic [31:0] DNA_ALPHABET = "ACGT";

    typedef struct {
        logic [7:0] ch;
        logic       eos;
    } base_item_t;

    typedef struct {
        logic        kind;
        logic [15:0] seq;
        logic [31:0] start;
        logic [31:0] value;
        logic        ovf;
        logic        last;
    } frag_record_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = rsfg_pkg::CFG_MOTIF_LEN;
    logic [63:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // base_char[7:0]
    logic        s_tlast = 1'b0; // end_of_sequence
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [rsfg_pkg::M_TDATA_W-1:0] m_tdata; // sequence_number[15:0] group_start[47:16]
                                             // record_value[79:48] overflowed[80]
    logic        m_tuser;        // record_kind
    logic        m_tlast;        // last_record

    restriction_site_fragment_grouper_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    initial begin : clock_gen
        forever #4 aclk = ~aclk;
    end

    initial begin : watchdog
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------- predictor
    logic [4:0]  len_cfg  = rsfg_pkg::RST_MOTIF_LEN;
    logic [63:0] lo_cfg   = rsfg_pkg::RST_MOTIF_LOW;
    logic [63:0] hi_cfg   = rsfg_pkg::RST_MOTIF_HIGH;
    logic [31:0] span_cfg = rsfg_pkg::RST_GROUP_SPAN;

    logic [7:0]  recent_bases [MOTIF_MAX];
    logic [31:0] pos_count;
    logic [31:0] last_site;
    logic        site_found;
    logic [31:0] group_origin;
    logic [31:0] lengths [LENGTH_SLOTS];
    int          stored;
    logic        dropped;
    logic [15:0] seq_index = '0;

    frag_record_t step_records [$];
    frag_record_t expected_records [$];
    base_item_t   pending_bases [$];

    int  items_queued = 0;
    int  items_taken = 0;
    int  mismatches = 0;
    bit  idle_on = 1'b1;
    bit  rx_hold = 1'b0;
    bit  start_rx_hold = 1'b0;

    function automatic int active_motif_len();
        return (len_cfg > 5'(MOTIF_MAX)) ? MOTIF_MAX : int'(len_cfg);
    endfunction

    function automatic logic [7:0] motif_char(input int k);
        logic [127:0] all_chars;
        all_chars = {hi_cfg, lo_cfg};
        return all_chars[8*k +: 8];
    endfunction

    task automatic clear_sequence();
        foreach (recent_bases[k]) recent_bases[k] = 8'h00;
        pos_count    = '0;
        last_site    = '0;
        site_found   = 1'b0;
        group_origin = '0;
        stored       = 0;
        dropped      = 1'b0;
    endtask

    task automatic emit_group();
        frag_record_t rec;
        rec = '{rsfg_pkg::KIND_HEADER, seq_index, group_origin, 32'(stored),
                dropped, 1'b0};
        step_records.insert(step_records.size(), rec);
        for (int i = 0; i < stored; i++) begin
            rec = '{rsfg_pkg::KIND_LENGTH, seq_index, group_origin, lengths[i],
                    1'b0, 1'b0};
            step_records.insert(step_records.size(), rec);
        end
    endtask

    task automatic predict_fragments(input logic [7:0] ch, input logic eos);
        int mlen;
        int k;
        logic hit;
        logic [31:0] site;
        logic [31:0] frag;
        step_records.delete();
        mlen = active_motif_len();
        for (k = MOTIF_MAX - 1; k > 0; k--) recent_bases[k] = recent_bases[k-1];
        recent_bases[0] = ch;
        if (pos_count != '1) pos_count++;
        hit = (mlen > 0) && (pos_count >= mlen);
        for (k = 0; hit && k < mlen; k++)
            if (recent_bases[mlen-1-k] != motif_char(k)) hit = 1'b0;
        if (hit) begin
            site = pos_count - 32'(mlen);
            if (!site_found) begin
                site_found   = 1'b1;
                last_site    = site;
                group_origin = site;
            end else begin
                frag      = site - last_site;
                last_site = site;
                // a site too far past the group's first one closes the group
                if (site - group_origin > span_cfg) begin
                    emit_group();
                    group_origin = site;
                    stored  = 0;
                    dropped = 1'b0;
                end
                if (stored < LENGTH_SLOTS) begin
                    lengths[stored] = frag;
                    stored++;
                end else begin
                    dropped = 1'b1;
                end
            end
        end
        if (eos) begin
            if (stored > rsfg_pkg::FLUSH_MIN) emit_group();
            clear_sequence();
            seq_index++;
        end
        if (step_records.size() > 0) step_records[step_records.size()-1].last = 1'b1;
        foreach (step_records[i])
            expected_records.insert(expected_records.size(), step_records[i]);
    endtask

    // ------------------------------------------------------------------- driver
    int tx_gap = 0;
    int rx_gap = 0;

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    always @(posedge aclk) begin : driver
        base_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_fragments(s_tdata, s_tlast);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_bases.size() > 0) begin
                    nxt = pending_bases.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.ch;
                    s_tlast  <= nxt.eos;
                    tx_gap   <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------ monitor
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_record();
        frag_record_t want;
        if (expected_records.size() == 0) begin
            $error("record arrived with nothing expected: kind %0d value %0d",
                   m_tuser, m_tdata[79:48]);
            mismatches++;
        end else begin
            want = expected_records.pop_front();
            check_field("record_kind", 32'(want.kind), 32'(m_tuser));
            check_field("sequence_number", 32'(want.seq), 32'(m_tdata[15:0]));
            check_field("group_start", want.start, m_tdata[47:16]);
            check_field("record_value", want.value, m_tdata[79:48]);
            check_field("overflowed", 32'(want.ovf), 32'(m_tdata[80]));
            check_field("last_record", 32'(want.last), 32'(m_tlast));
        end
    endtask

    always @(posedge aclk) begin : monitor
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end else begin
            if (m_tvalid && m_tready) check_record();
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap   <= rx_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_gap   <= pick_gap();
            end
        end
    end

    // long receiver hold-off, timed here so the sender keeps offering meanwhile
    initial begin : rx_hold_off
        wait (start_rx_hold);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // ----------------------------------------------------------------- stimulus
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] len_word(input logic [4:0] len);
        logic [63:0] w;
        w = rand64();
        w[4:0] = len;
        return w;
    endfunction

    task automatic push_base(input logic [7:0] ch, input logic eos);
        base_item_t item;
        item.ch  = ch;
        item.eos = eos;
        pending_bases.insert(pending_bases.size(), item);
        items_queued++;
    endtask

    task automatic push_string(input string s);
        for (int i = 0; i < s.len(); i++) push_base(s[i], i == s.len() - 1);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            rsfg_pkg::CFG_MOTIF_LEN:  len_cfg  = val[4:0];
            rsfg_pkg::CFG_MOTIF_LOW:  lo_cfg   = val;
            rsfg_pkg::CFG_MOTIF_HIGH: hi_cfg   = val;
            rsfg_pkg::CFG_GROUP_SPAN: span_cfg = val[31:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [63:0] len, input logic [127:0] motif,
                                input logic [63:0] span);
        write_reg(rsfg_pkg::CFG_MOTIF_LEN, len);
        write_reg(rsfg_pkg::CFG_MOTIF_LOW, motif[63:0]);
        write_reg(rsfg_pkg::CFG_MOTIF_HIGH, motif[127:64]);
        write_reg(rsfg_pkg::CFG_GROUP_SPAN, span);
    endtask

    // all queued bases taken, all records in, then room for a trailing group
    task automatic wait_idle();
        while (items_taken != items_queued) @(posedge aclk);
        while (expected_records.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // whole sequences: copies of the motif (some cut short), motif letters, noise
    task automatic queue_phase(input int n_items, input int min_len, input int max_len,
                               input int motif_pct, input int noise_pct);
        int produced;
        int seq_len;
        int done_in_seq;
        int mlen;
        int r;
        int k;
        int cut;
        int pick;
        logic [7:0] ch;
        mlen = active_motif_len();
        produced = 0;
        while (produced < n_items) begin
            seq_len = $urandom_range(max_len, min_len);
            done_in_seq = 0;
            while (done_in_seq < seq_len) begin
                r = $urandom_range(99);
                if (r < motif_pct && mlen > 0) begin
                    cut = ($urandom_range(4) == 0) ? $urandom_range(mlen, 1) : mlen;
                    for (k = 0; k < cut && done_in_seq < seq_len; k++) begin
                        push_base(motif_char(k), done_in_seq == seq_len - 1);
                        done_in_seq++;
                    end
                end else begin
                    if (r < motif_pct + noise_pct) begin
                        ch = 8'($urandom_range(255));
                    end else if (mlen > 0) begin
                        ch = motif_char($urandom_range(mlen - 1));
                    end else begin
                        pick = $urandom_range(3);
                        ch = DNA_ALPHABET[8*pick +: 8];
                    end
                    push_base(ch, done_in_seq == seq_len - 1);
                    done_in_seq++;
                end
            end
            produced += seq_len;
        end
    endtask

    initial begin : stimulus
        logic [127:0] motif_wide;
        int mlen;
        int pick;
        int k;
        clear_sequence();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: site ending on the final base, then extreme characters
        push_string("ACTAGT");
        push_base(8'h00, 1'b0);
        push_base(8'hFF, 1'b1);
        wait_idle();

        // single-letter motif, unbounded span: flush with four lengths, then none
        write_config(64'd1, 128'h41, 64'hFFFF_FFFF);
        push_string("AAAAA");
        push_string("AAAA");
        wait_idle();

        // zero span: every further site closes a group, the first one empty
        write_reg(rsfg_pkg::CFG_GROUP_SPAN, 64'd0);
        push_string("AAAA");
        wait_idle();

        // zero motif length finds nothing
        write_reg(rsfg_pkg::CFG_MOTIF_LEN, 64'd0);
        push_string("AA");
        wait_idle();

        // dense single-letter sites, small span; receiver stalls long meanwhile
        motif_wide = {rand64(), rand64()};
        motif_wide[7:0] = "A";
        write_config(len_word(5'd1), motif_wide, {$urandom, 32'($urandom_range(20))});
        queue_phase(90, 1, 30, 40, 10);
        start_rx_hold = 1'b1;
        wait_idle();

        // short DNA motifs, no idling; sender pauses halfway until all is in
        idle_on = 1'b0;
        mlen = $urandom_range(4, 2);
        motif_wide = {rand64(), rand64()};
        for (k = 0; k < mlen; k++) begin
            pick = $urandom_range(3);
            motif_wide[8*k +: 8] = DNA_ALPHABET[8*pick +: 8];
        end
        write_config(len_word(5'(mlen)), motif_wide, {$urandom, 32'($urandom_range(60, 5))});
        queue_phase(40, 5, 40, 30, 10);
        wait_idle();
        queue_phase(40, 5, 40, 30, 10);
        wait_idle();
        idle_on = 1'b1;

        // length above the maximum saturates: two-letter sixteen-character motif
        for (k = 0; k < MOTIF_MAX; k++)
            motif_wide[8*k +: 8] = ($urandom_range(1) != 0) ? "A" : "C";
        write_config(len_word(5'($urandom_range(31, 17))), motif_wide,
                     {$urandom, 32'($urandom_range(100))});
        queue_phase(40, 20, 60, 35, 5);
        wait_idle();

        // zero length with random motif bytes and noise
        write_config(len_word(5'd0), {rand64(), rand64()}, rand64());
        queue_phase(20, 1, 15, 0, 50);
        wait_idle();

        // full sixteen random bytes, random span
        write_config(len_word(5'd16), {rand64(), rand64()}, rand64());
        queue_phase(40, 20, 50, 30, 30);
        wait_idle();

        // one long run of a single letter overfills the length store
        motif_wide = {rand64(), rand64()};
        motif_wide[7:0] = "T";
        write_config(len_word(5'd1), motif_wide, {$urandom, 32'hFFFF_FFFF});
        queue_phase(1, 66, 80, 95, 0);
        wait_idle();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
